>>> sv/lpd_pkg.sv
package lpd_pkg;

    localparam int BYTE_W            = 8;
    localparam int MAX_W             = 10;
    localparam int HDR_CNT_W         = 4;
    localparam int LEN_W             = 32;
    localparam int PAYLOAD_COUNT_DEF = 10;

    localparam logic [HDR_CNT_W-1:0] HDR_LEN  = HDR_CNT_W'(12);
    localparam logic [HDR_CNT_W-1:0] HDR_SKIP = HDR_CNT_W'(8);
    localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_LEN - HDR_CNT_W'(1);

    localparam logic [MAX_W-1:0] MAX_PAYLOAD_RESET = MAX_W'(1000);

    // Register word index on the configuration port.
    localparam logic REG_MAX_PAYLOAD = 1'b0;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              last_of_message;
        logic              empty_message;
        logic              length_error;
    } t_result;

endpackage

>>> sv/lpd_out_buf.sv
module lpd_out_buf
    import lpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_push_data,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_data,
    output logic    o_full
);

    logic    r_out_valid;
    t_result r_out_data;
    logic    r_skid_valid;
    t_result r_skid_data;
    logic    w_slot_free;

    // The main slot frees up when it is empty or its transaction completes now.
    assign w_slot_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_slot_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (i_push) begin
                r_out_data <= i_push_data;
            end
        end else if (i_push) begin
            r_skid_data <= i_push_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_full  = r_skid_valid;

endmodule

>>> sv/length_prefixed_deframer.sv
// Length-prefixed message deframer.
// The input channel (i_in_valid, o_in_stall, i_in_byte) carries one stream byte
// per transaction. Every message opens with a 12-byte header whose last four
// bytes are a big-endian payload length. The output channel (o_out_valid,
// i_out_stall) carries one result per payload byte, with last_of_message on
// the final one; a zero length gives one empty_message result, and a length
// above max_payload gives one length_error result, after which every byte is
// dropped until reset. Header bytes give no result.
// A byte is parsed in the cycle it is accepted and its result is registered in
// the output buffer. One byte is taken every cycle while o_in_stall is low; a
// two-entry output buffer lets the block keep accepting while one result waits
// on a stalled receiver, and o_in_stall rises only once both entries are full.
// Reset clears the parser, the sticky error and the output buffer, and sets
// max_payload to 1000. max_payload is written over the APB port at address 0
// and should only be changed while no message is in flight.
module length_prefixed_deframer
    import lpd_pkg::*;
#(
    parameter int PAYLOAD_COUNT_BITS = PAYLOAD_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic              o_last_of_message,
    output logic              o_empty_message,
    output logic              o_length_error
);

    localparam int CNT_W = PAYLOAD_COUNT_BITS;
    localparam int LIM_W = (CNT_W > MAX_W) ? CNT_W : MAX_W;

    logic [MAX_W-1:0]     r_max_payload;
    logic [HDR_CNT_W-1:0] r_header_count, n_header_count;
    logic [LEN_W-1:0]     r_length_accum, n_length_accum;
    logic [CNT_W-1:0]     r_payload_left, n_payload_left;
    logic                 r_in_payload, n_in_payload;
    logic                 r_stuck_error, n_stuck_error;

    logic                 w_cfg_write;
    logic                 w_accept;
    logic [LIM_W-1:0]     w_max_ext;
    logic [LIM_W-1:0]     w_mask_ext;
    logic [LIM_W-1:0]     w_limit;
    logic                 w_res_valid;
    t_result              w_res;
    t_result              w_out;
    logic                 w_full;

    // Configuration port.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (w_cfg_write && paddr[2] == REG_MAX_PAYLOAD) begin
            r_max_payload <= pwdata[MAX_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_PAYLOAD) begin
            prdata = 32'(r_max_payload);
        end
    end

    // A length must also fit the payload counter.
    assign w_max_ext  = LIM_W'(r_max_payload);
    assign w_mask_ext = LIM_W'({CNT_W{1'b1}});
    assign w_limit    = (w_max_ext > w_mask_ext) ? w_mask_ext : w_max_ext;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_header_count = r_header_count;
        n_length_accum = r_length_accum;
        n_payload_left = r_payload_left;
        n_in_payload   = r_in_payload;
        n_stuck_error  = r_stuck_error;
        w_res_valid    = 1'b0;
        w_res          = '0;
        if (w_accept && !r_stuck_error) begin
            if (r_in_payload) begin
                n_payload_left     = r_payload_left - CNT_W'(1);
                w_res_valid        = 1'b1;
                w_res.payload_byte = i_in_byte;
                if (n_payload_left == '0) begin
                    n_in_payload          = 1'b0;
                    n_header_count        = '0;
                    w_res.last_of_message = 1'b1;
                end
            end else begin
                if (r_header_count >= HDR_SKIP) begin
                    n_length_accum = {r_length_accum[LEN_W-BYTE_W-1:0], i_in_byte};
                end
                n_header_count = r_header_count + HDR_CNT_W'(1);
                if (r_header_count == HDR_LAST) begin
                    n_header_count = '0;
                    if (n_length_accum > LEN_W'(w_limit)) begin
                        n_stuck_error      = 1'b1;
                        w_res_valid        = 1'b1;
                        w_res.length_error = 1'b1;
                    end else if (n_length_accum == '0) begin
                        w_res_valid           = 1'b1;
                        w_res.last_of_message = 1'b1;
                        w_res.empty_message   = 1'b1;
                    end else begin
                        n_payload_left = n_length_accum[CNT_W-1:0];
                        n_in_payload   = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_count <= '0;
            r_length_accum <= '0;
            r_payload_left <= '0;
            r_in_payload   <= 1'b0;
            r_stuck_error  <= 1'b0;
        end else begin
            r_header_count <= n_header_count;
            r_length_accum <= n_length_accum;
            r_payload_left <= n_payload_left;
            r_in_payload   <= n_in_payload;
            r_stuck_error  <= n_stuck_error;
        end
    end

    lpd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_res_valid),
        .i_push_data (w_res),
        .i_stall     (i_out_stall),
        .o_valid     (o_out_valid),
        .o_data      (w_out),
        .o_full      (w_full)
    );

    assign o_payload_byte    = w_out.payload_byte;
    assign o_last_of_message = w_out.last_of_message;
    assign o_empty_message   = w_out.empty_message;
    assign o_length_error    = w_out.length_error;

`ifndef SYNTHESIS
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stuck_error |=> r_stuck_error)
        else $error("sticky error cleared without reset");

    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_payload_left != '0 && !r_stuck_error))
        else $error("payload phase with zero count or after error");

    a_header_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> r_header_count == '0)
        else $error("header count not cleared during payload");
`endif

endmodule

>>> test/length_prefixed_deframer_check.sv
module length_prefixed_deframer_check
    import lpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    input  logic              i_in_valid,
    input  logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              o_out_valid,
    input  logic              i_out_stall,
    input  logic [BYTE_W-1:0] o_payload_byte,
    input  logic              o_last_of_message,
    input  logic              o_empty_message,
    input  logic              o_length_error,
    output int                o_error_count,
    output int                o_pending
);

    localparam int unsigned LEFT_MAX = (1 << PAYLOAD_COUNT_DEF) - 1;

    logic [MAX_W-1:0]             max_len;
    logic [HDR_CNT_W-1:0]         hdr_seen;
    logic [LEN_W-1:0]             len_acc;
    logic [PAYLOAD_COUNT_DEF-1:0] bytes_left;
    logic                         in_body;
    logic                         stuck;
    t_result                      expected_q[$];

    function automatic t_result make_result(input logic [BYTE_W-1:0] b, input logic last,
                                            input logic empty, input logic err);
        t_result r;
        r.payload_byte    = b;
        r.last_of_message = last;
        r.empty_message   = empty;
        r.length_error    = err;
        return r;
    endfunction

    // Advances the deframing state by one stream byte and queues the result it causes.
    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] accept_max;
        if (stuck) begin
            return;
        end
        if (in_body) begin
            bytes_left = bytes_left - 1'b1;
            if (bytes_left == '0) begin
                in_body  = 1'b0;
                hdr_seen = '0;
                expected_q.push_back(make_result(b, 1'b1, 1'b0, 1'b0));
            end else begin
                expected_q.push_back(make_result(b, 1'b0, 1'b0, 1'b0));
            end
            return;
        end
        if (hdr_seen == '0) begin
            len_acc = '0;
        end
        if (hdr_seen >= HDR_SKIP) begin
            len_acc = {len_acc[LEN_W-BYTE_W-1:0], b};
        end
        hdr_seen = hdr_seen + 1'b1;
        if (hdr_seen < HDR_LEN) begin
            return;
        end
        hdr_seen = '0;
        // The payload counter bounds the usable maximum when it is narrower than the register.
        accept_max = (max_len > LEFT_MAX) ? LEN_W'(LEFT_MAX) : LEN_W'(max_len);
        if (len_acc > accept_max) begin
            stuck = 1'b1;
            expected_q.push_back(make_result('0, 1'b0, 1'b0, 1'b1));
        end else if (len_acc == '0) begin
            expected_q.push_back(make_result('0, 1'b1, 1'b1, 1'b0));
        end else begin
            bytes_left = len_acc[PAYLOAD_COUNT_DEF-1:0];
            in_body    = 1'b1;
        end
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            max_len    = MAX_PAYLOAD_RESET;
            hdr_seen   = '0;
            len_acc    = '0;
            bytes_left = '0;
            in_body    = 1'b0;
            stuck      = 1'b0;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && (paddr >> 2) == 3'(REG_MAX_PAYLOAD)) begin
                max_len = pwdata[MAX_W-1:0];
            end
            if (i_in_valid && !o_in_stall) begin
                deframe_byte(i_in_byte);
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result: payload_byte %0d last %0b empty %0b error %0b",
                           o_payload_byte, o_last_of_message, o_empty_message, o_length_error);
                    o_error_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("payload_byte", want.payload_byte, o_payload_byte);
                    check_field("last_of_message", want.last_of_message, o_last_of_message);
                    check_field("empty_message", want.empty_message, o_empty_message);
                    check_field("length_error", want.length_error, o_length_error);
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

>>> test/length_prefixed_deframer_test.sv
module length_prefixed_deframer_test;
    import lpd_pkg::*;

    localparam int ITEM_TARGET = 1650;
    localparam int QUIET_FROM  = 1400;
    localparam int IDLE_LIMIT  = 500;
    localparam int BIG_LEN     = 1023;

    localparam logic [2:0] MAX_ADDR    = 3'(REG_MAX_PAYLOAD) << 2;
    localparam logic [2:0] UNUSED_ADDR = MAX_ADDR + 3'd4;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [BYTE_W-1:0] i_in_byte;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [BYTE_W-1:0] o_payload_byte;
    logic              o_last_of_message;
    logic              o_empty_message;
    logic              o_length_error;

    int               error_count;
    int               pending;
    int               bytes_sent;
    int               big_bytes;
    int               frames_sent;
    int               empty_sent;
    int               payload_sent;
    int               settings_used;
    int               idle_cycles;
    bit               quiet;
    logic [MAX_W-1:0] cur_max;

    length_prefixed_deframer u_top (.*);

    length_prefixed_deframer_check u_check (
        .o_error_count(error_count),
        .o_pending(pending),
        .*
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls in short random bursts until the quiet part of the run.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (psel && penable)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        bytes_sent++;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stops the sender and waits until every predicted result has been delivered.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_max(input logic [MAX_W-1:0] value);
        logic [31:0] data;
        drain();
        // Bits above the register width are set at random; the block must drop them.
        data             = $urandom;
        data[MAX_W-1:0]  = value;
        write_reg(MAX_ADDR, data);
        cur_max = value;
        settings_used++;
    endtask

    // A fill below zero gives random skipped and payload bytes, else all take that value.
    task automatic send_frame(input logic [LEN_W-1:0] len, input int fill);
        int i;
        for (i = 0; i < 8; i++) begin
            send_byte(fill < 0 ? BYTE_W'($urandom) : BYTE_W'(fill));
        end
        for (i = 3; i >= 0; i--) begin
            send_byte(len[8*i +: 8]);
        end
        if (len <= LEN_W'(cur_max)) begin
            for (i = 0; i < int'(len); i++) begin
                send_byte(fill < 0 ? BYTE_W'($urandom) : BYTE_W'(fill));
            end
            payload_sent += int'(len);
        end
        frames_sent++;
        if (len == '0) begin
            empty_sent++;
        end
    endtask

    function automatic int unsigned pick_len();
        int unsigned r;
        int unsigned short_cap;
        int unsigned mid_cap;
        r         = $urandom_range(0, 9);
        short_cap = (cur_max < 12) ? cur_max : 12;
        mid_cap   = (cur_max < 80) ? cur_max : 80;
        if (cur_max == '0 || r < 2) begin
            return 0;
        end
        if (r == 2 && cur_max <= 64) begin
            return cur_max;
        end
        if (r == 3) begin
            return $urandom_range(1, mid_cap);
        end
        return $urandom_range(1, short_cap);
    endfunction

    initial begin
        int               phase;
        int               phase_end;
        logic [LEN_W-1:0] bad_len;
        logic [MAX_W-1:0] next_max;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_byte  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        quiet      = 1'b0;
        cur_max    = MAX_PAYLOAD_RESET;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // An empty message with all-zero bytes, then a one-byte message whose skipped and payload bytes are all ones.
        send_frame(0, 8'h00);
        send_frame(1, 8'hFF);

        phase = 0;
        while (bytes_sent < ITEM_TARGET) begin
            if (phase > 0) begin
                case (phase)
                    1:       next_max = '0;
                    2:       next_max = MAX_W'(1);
                    3:       next_max = '1;
                    4:       next_max = MAX_W'(5);
                    default: next_max = ($urandom_range(0, 3) == 0) ?
                                        MAX_W'($urandom_range(0, 1023)) :
                                        MAX_W'($urandom_range(2, 40));
                endcase
                set_max(next_max);
                if (phase == 1) begin
                    write_reg(UNUSED_ADDR, $urandom);
                end
            end
            if (cur_max == MAX_W'(BIG_LEN) && big_bytes == 0) begin
                send_frame(BIG_LEN, -1);
                big_bytes = BIG_LEN;
            end
            phase_end = bytes_sent + 100;
            while (bytes_sent < phase_end) begin
                quiet = (bytes_sent >= QUIET_FROM);
                send_frame(pick_len(), -1);
            end
            phase++;
        end

        // A length just above the maximum or negative as signed locks the block up.
        drain();
        if ($urandom_range(0, 1) == 1) begin
            bad_len = LEN_W'(cur_max) + 1'b1;
        end else begin
            bad_len = {1'b1, 31'($urandom)};
        end
        send_frame(bad_len, -1);
        repeat (12) send_byte($urandom);
        set_max(MAX_W'($urandom_range(0, 1023)));
        repeat (12) send_byte($urandom);
        drain();
        repeat (10) @(negedge i_clk);

        $display("Sent %0d bytes in %0d messages (%0d empty, %0d payload bytes).",
                 bytes_sent, frames_sent, empty_sent, payload_sent);
        $display("Used %0d register writes; ended on a sticky length error of 0x%08h.",
                 settings_used, bad_len);
        if (error_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/lpd_pkg.sv
sv/lpd_out_buf.sv
sv/length_prefixed_deframer.sv
test/length_prefixed_deframer_check.sv
test/length_prefixed_deframer_test.sv
